[rtl/core/ppe_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the palette pixel expander.
// No dependencies; every other file of the block uses it.
package ppe_pkg;

   localparam int BYTE_W  = 8;
   localparam int COLOR_W = 16;
   localparam int COUNT_W = 16;
   localparam int BPP_W   = 3;
   localparam int CSR_W   = 64;
   localparam int IDX_W   = 3;
   localparam int PAL_ENTRIES = 16;
   localparam int PAL_REGS    = 4;
   localparam int PAL_IDX_W   = 4;
   localparam int LEFT_W      = 4;

   // register indexes on the csr port
   localparam logic [IDX_W-1:0] REG_BPP        = 3'd0;
   localparam logic [IDX_W-1:0] REG_COUNT      = 3'd1;
   localparam logic [IDX_W-1:0] REG_PAL_LOW    = 3'd2;
   localparam logic [IDX_W-1:0] REG_PAL_MIDLO  = 3'd3;
   localparam logic [IDX_W-1:0] REG_PAL_MIDHI  = 3'd4;
   localparam logic [IDX_W-1:0] REG_PAL_HIGH   = 3'd5;

   // index width codes carried with each queued item
   localparam logic [1:0] DEPTH_1 = 2'd0;
   localparam logic [1:0] DEPTH_2 = 2'd1;
   localparam logic [1:0] DEPTH_4 = 2'd2;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = 1;
   localparam int FIFO_CNT_W = 2;

   typedef logic [PAL_ENTRIES-1:0][COLOR_W-1:0] palette_type;

   typedef struct packed {
      logic [BYTE_W-1:0] packed_byte;
      logic [LEFT_W-1:0] count;     // pixels to emit, 1..8
      logic [1:0]        depth;
      logic              image_last; // last pixel of this byte closes the image
   } item_type;

   typedef struct packed {
      logic [BPP_W-1:0]   bits_per_pixel;
      logic [COUNT_W-1:0] pixel_count;
   } front_cfg_type;

endpackage

[rtl/core/ppe_if.sv]
`timescale 1ns / 1ps
// Handshake channels of the palette pixel expander: byte requests and pixels.
// Depends on ppe_pkg.
interface ppe_req_if;
   logic                     valid;
   logic                     ready;
   logic [ppe_pkg::BYTE_W-1:0] packed_byte;
   logic                     image_start;
   modport source (output valid, output packed_byte, output image_start, input ready);
   modport sink   (input valid, input packed_byte, input image_start, output ready);
endinterface

interface ppe_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [ppe_pkg::COLOR_W-1:0] pixel_color;
   logic                      byte_final;
   logic                      image_final;
   modport source (output valid, output pixel_color, output byte_final,
                   output image_final, input ready);
   modport sink   (input valid, input pixel_color, input byte_final,
                   input image_final, output ready);
endinterface

[rtl/core/ppe_front.sv]
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks the image pixel counter and works out how
// many pixels each byte yields. Depends on ppe_pkg.
module ppe_front (
   input  logic                          clock,
   input  logic                          reset,
   input  ppe_pkg::front_cfg_type        cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [ppe_pkg::BYTE_W-1:0]    in_byte,
   input  logic                          in_start,
   input  logic                          q_full,
   output logic                          q_push,
   output ppe_pkg::item_type             q_item
);
   logic [ppe_pkg::COUNT_W-1:0] emitted_ff, emitted_in;
   logic [ppe_pkg::COUNT_W-1:0] base, remain;
   logic [ppe_pkg::LEFT_W-1:0]  per_byte, n;
   logic [1:0]                  depth;
   logic                        depth_ok, accept;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;

   always_comb begin
      depth_ok = 1'b1;
      depth    = ppe_pkg::DEPTH_1;
      per_byte = 4'd8;
      case (cfg.bits_per_pixel)
         3'd1: begin
            depth    = ppe_pkg::DEPTH_1;
            per_byte = 4'd8;
         end
         3'd2: begin
            depth    = ppe_pkg::DEPTH_2;
            per_byte = 4'd4;
         end
         3'd4: begin
            depth    = ppe_pkg::DEPTH_4;
            per_byte = 4'd2;
         end
         default: depth_ok = 1'b0;
      endcase
   end

   always_comb begin
      base   = in_start ? '0 : emitted_ff;
      remain = (base < cfg.pixel_count) ? (cfg.pixel_count - base) : '0;
      if (!depth_ok)
         n = '0;
      else if (remain < {{(ppe_pkg::COUNT_W-ppe_pkg::LEFT_W){1'b0}}, per_byte})
         n = remain[ppe_pkg::LEFT_W-1:0];
      else
         n = per_byte;
      emitted_in = base + {{(ppe_pkg::COUNT_W-ppe_pkg::LEFT_W){1'b0}}, n};
   end

   // bytes that yield nothing never reach the queue
   assign q_push              = accept && (n != '0);
   assign q_item.packed_byte  = in_byte;
   assign q_item.count        = n;
   assign q_item.depth        = depth;
   assign q_item.image_last   =
      (remain <= {{(ppe_pkg::COUNT_W-ppe_pkg::LEFT_W){1'b0}}, per_byte});

   always_ff @(posedge clock) begin
      if (reset) begin
         emitted_ff <= '0;
      end else if (accept) begin
         emitted_ff <= emitted_in;
      end
   end
endmodule

[rtl/core/ppe_fifo.sv]
`timescale 1ns / 1ps
// Two-entry queue of classified items between front and back end.
// Depends on ppe_pkg.
module ppe_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ppe_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              valid,
   output ppe_pkg::item_type pop_item
);
   ppe_pkg::item_type              entries_ff [ppe_pkg::FIFO_DEPTH];
   logic [ppe_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [ppe_pkg::FIFO_CNT_W-1:0] count_ff;

   assign full     = (count_ff == ppe_pkg::FIFO_CNT_W'(ppe_pkg::FIFO_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_item = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push)
         entries_ff[wr_ptr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)
            count_ff <= count_ff + 1'b1;
         else if (pop && !push)
            count_ff <= count_ff - 1'b1;
      end
   end
endmodule

[rtl/core/ppe_back.sv]
`timescale 1ns / 1ps
// Back end: unpacks one queued byte MSB first, one pixel per cycle while the
// output is not stalled, looks up the palette and drives the output register. Depends on ppe_pkg.
module ppe_back (
   input  logic                         clock,
   input  logic                         reset,
   input  ppe_pkg::palette_type         palette,
   input  logic                         q_valid,
   input  ppe_pkg::item_type            q_item,
   output logic                         q_pop,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [ppe_pkg::COLOR_W-1:0]  out_color,
   output logic                         out_byte_final,
   output logic                         out_image_final
);
   logic                          cur_valid_ff, cur_valid_in;
   logic [ppe_pkg::BYTE_W-1:0]    cur_byte_ff, cur_byte_in;
   logic [ppe_pkg::LEFT_W-1:0]    cur_left_ff, cur_left_in;
   logic [1:0]                    cur_depth_ff, cur_depth_in;
   logic                          cur_last_ff, cur_last_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ppe_pkg::COLOR_W-1:0]   rsp_color_ff, rsp_color_in;
   logic                          rsp_byte_ff, rsp_byte_in;
   logic                          rsp_image_ff, rsp_image_in;
   logic [ppe_pkg::PAL_IDX_W-1:0] pix_idx;
   logic [ppe_pkg::BYTE_W-1:0]    shifted;
   logic                          out_free, step, last_pix;

   assign out_free = !rsp_valid_ff || out_ready;
   assign step     = cur_valid_ff && out_free;
   assign last_pix = (cur_left_ff == 4'd1);
   assign q_pop    = q_valid && (!cur_valid_ff || (step && last_pix));

   always_comb begin
      case (cur_depth_ff)
         ppe_pkg::DEPTH_2: begin
            pix_idx = {2'b00, cur_byte_ff[7:6]};
            shifted = {cur_byte_ff[5:0], 2'b00};
         end
         ppe_pkg::DEPTH_4: begin
            pix_idx = cur_byte_ff[7:4];
            shifted = {cur_byte_ff[3:0], 4'b0000};
         end
         default: begin
            pix_idx = {3'b000, cur_byte_ff[7]};
            shifted = {cur_byte_ff[6:0], 1'b0};
         end
      endcase
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_byte_in  = cur_byte_ff;
      cur_left_in  = cur_left_ff;
      cur_depth_in = cur_depth_ff;
      cur_last_in  = cur_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_color_in = rsp_color_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_image_in = rsp_image_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_color_in = palette[pix_idx];
         rsp_byte_in  = last_pix;
         rsp_image_in = last_pix && cur_last_ff;
         cur_byte_in  = shifted;
         cur_left_in  = cur_left_ff - 1'b1;
         if (last_pix)
            cur_valid_in = 1'b0;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_byte_in  = q_item.packed_byte;
         cur_left_in  = q_item.count;
         cur_depth_in = q_item.depth;
         cur_last_in  = q_item.image_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_byte_ff  <= cur_byte_in;
      cur_left_ff  <= cur_left_in;
      cur_depth_ff <= cur_depth_in;
      cur_last_ff  <= cur_last_in;
      rsp_color_ff <= rsp_color_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_image_ff <= rsp_image_in;
   end

   assign out_valid       = rsp_valid_ff;
   assign out_color       = rsp_color_ff;
   assign out_byte_final  = rsp_byte_ff;
   assign out_image_final = rsp_image_ff;
endmodule

[rtl/core/palette_pixel_expander_top.sv]
`timescale 1ns / 1ps
// Top level of the palette pixel expander: csr registers, front, queue, back.
// Depends on ppe_pkg, ppe_if, ppe_front, ppe_fifo, ppe_back.
//
//   channel  | dir | handshake     | payload
//   req_ch   | in  | valid/ready   | packed_byte[7:0], image_start
//   rsp_ch   | out | valid/ready   | pixel_color[15:0], byte_final, image_final
//   csr_*    | in  | csr_we only   | csr_index[2:0], csr_wdata[63:0]
//
// A byte yields 8, 4 or 2 pixels at 1, 2 or 4 bits per pixel (fewer at the tail
// of an image); the back end emits one pixel per cycle unless the output stalls.
// A byte that yields no pixel is accepted by the front end and never queues.
// The first pixel of a byte is offered at the earliest once the byte has passed
// the queue, the unpack register and the output register.
// Reset is synchronous; it empties the queue and clears the pixel counter.
// Front and back stall independently across the two-entry queue.
module palette_pixel_expander_top (
   input  logic                         clock,
   input  logic                         reset,
   ppe_req_if.sink                      req_ch,
   ppe_rsp_if.source                    rsp_ch,
   input  logic                         csr_we,
   input  logic [ppe_pkg::IDX_W-1:0]    csr_index,
   input  logic [ppe_pkg::CSR_W-1:0]    csr_wdata
);
   logic [ppe_pkg::BPP_W-1:0]                       bpp_ff;
   logic [ppe_pkg::COUNT_W-1:0]                     count_ff;
   logic [ppe_pkg::PAL_REGS-1:0][ppe_pkg::CSR_W-1:0] pal_ff;

   ppe_pkg::front_cfg_type front_cfg;
   ppe_pkg::item_type      push_item, pop_item;
   logic                   q_push, q_pop, q_full, q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff   <= ppe_pkg::BPP_W'(1);
         count_ff <= '0;
         pal_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            ppe_pkg::REG_BPP:       bpp_ff    <= csr_wdata[ppe_pkg::BPP_W-1:0];
            ppe_pkg::REG_COUNT:     count_ff  <= csr_wdata[ppe_pkg::COUNT_W-1:0];
            ppe_pkg::REG_PAL_LOW:   pal_ff[0] <= csr_wdata;
            ppe_pkg::REG_PAL_MIDLO: pal_ff[1] <= csr_wdata;
            ppe_pkg::REG_PAL_MIDHI: pal_ff[2] <= csr_wdata;
            ppe_pkg::REG_PAL_HIGH:  pal_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign front_cfg.bits_per_pixel = bpp_ff;
   assign front_cfg.pixel_count    = count_ff;

   ppe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (front_cfg),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .in_byte  (req_ch.packed_byte),
      .in_start (req_ch.image_start),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (push_item)
   );

   ppe_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (pop_item)
   );

   // entry 0 sits in the low bits of the first palette register
   ppe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .palette         (ppe_pkg::palette_type'(pal_ff)),
      .q_valid         (q_valid),
      .q_item          (pop_item),
      .q_pop           (q_pop),
      .out_valid       (rsp_ch.valid),
      .out_ready       (rsp_ch.ready),
      .out_color       (rsp_ch.pixel_color),
      .out_byte_final  (rsp_ch.byte_final),
      .out_image_final (rsp_ch.image_final)
   );
endmodule

[rtl/core/ppe_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the palette pixel expander, bound to the top level.
// Depends on ppe_pkg and palette_pixel_expander_top.
module ppe_port_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ppe_pkg::COLOR_W-1:0] rsp_color,
   input logic                        rsp_byte_final,
   input logic                        rsp_image_final
);
   // a stalled pixel holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_color)
         && $stable(rsp_byte_final) && $stable(rsp_image_final))
      else $error("stalled pixel changed");

   // the image closes only on the last pixel of a byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_final |-> rsp_byte_final)
      else $error("image_final without byte_final");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel valid after reset");

   // the queue is empty after reset, so the next byte is taken at once
   assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("not ready after reset");
endmodule

bind palette_pixel_expander_top ppe_port_checker u_ppe_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_color       (rsp_ch.pixel_color),
   .rsp_byte_final  (rsp_ch.byte_final),
   .rsp_image_final (rsp_ch.image_final)
);
